// ===== hdl/wvsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wvsc_pkg
// Shared types, constants, saturation and the control program of the
// wave-variable slave controller.
// ----------------------------------------------------------------------------
package wvsc_pkg;

	localparam int unsigned AXES_DEF = 3;
	localparam int unsigned DW       = 32;
	localparam int unsigned GW       = 31;
	localparam int unsigned AXW      = 2;
	localparam int unsigned CIW      = 3;
	localparam int unsigned PCW      = 4;

	typedef logic signed [DW-1:0] q_t;
	typedef logic [GW-1:0]        gain_t;

	typedef enum logic [CIW-1:0] {
		REG_STEP_TIME   = 3'd0,
		REG_DELAY_TIME  = 3'd1,
		REG_SQRT_2B     = 3'd2,
		REG_SQRT_2_OV_B = 3'd3,
		REG_INV_DAMPING = 3'd4,
		REG_POS_GAIN    = 3'd5,
		REG_VEL_GAIN    = 3'd6,
		REG_DRIFT_GAIN  = 3'd7
	} cfg_reg_t;

	localparam gain_t RST_STEP_TIME   = 31'd66;
	localparam gain_t RST_DELAY_TIME  = 31'd0;
	localparam gain_t RST_SQRT_2B     = 31'd65536;
	localparam gain_t RST_SQRT_2_OV_B = 31'd131072;
	localparam gain_t RST_INV_DAMPING = 31'd105703;
	localparam gain_t RST_POS_GAIN    = 31'd786432;
	localparam gain_t RST_VEL_GAIN    = 31'd7864;
	localparam gain_t RST_DRIFT_GAIN  = 31'd33;

	typedef struct packed {
		gain_t t;
		gain_t td;
		gain_t s2b;
		gain_t s2ob;
		gain_t invd;
		gain_t kp;
		gain_t kv;
		gain_t lambda;
	} gains_t;

	typedef struct packed {
		q_t win;
		q_t rate;
		q_t cmd;
		q_t vel;
		q_t pos;
		q_t jd;
		q_t vd;
	} opnd_t;

	typedef struct packed {
		q_t u;
		q_t jdn;
		q_t vdn;
		q_t tau;
		q_t wout;
	} dp_res_t;

	// multiplier operand A
	typedef enum logic [3:0] {
		A_RATE, A_VD, A_CMD_JD, A_U, A_VEL, A_POS_JDN, A_ACC, A_VDN_VEL, A_JDN_POS
	} a_sel_t;

	// multiplier operand B (gain)
	typedef enum logic [2:0] {
		B_TD, B_T, B_LAMBDA, B_S2B, B_KV, B_KP, B_INVD, B_S2OB
	} b_sel_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

	typedef enum logic [2:0] {WR_NONE, WR_U, WR_JDN, WR_VDN, WR_TAU, WR_WOUT} wr_op_t;

	// J_WAIT_IN: hold until a request, then jmp_to on a bad axis else next
	// J_WAIT_OUT: hold until the output register is free, then jmp_to
	typedef enum logic [1:0] {J_NEXT, J_WAIT_IN, J_WAIT_OUT} jmp_t;

	typedef struct packed {
		jmp_t           jmp;
		logic [PCW-1:0] jmp_to;
		logic           mul_en;
		a_sel_t         a_sel;
		b_sel_t         b_sel;
		acc_op_t        acc_op;
		wr_op_t         wr_op;
	} ucode_t;

	localparam logic [PCW-1:0] PC_WAIT = 4'd0;
	localparam logic [PCW-1:0] PC_OUT  = 4'd14;

	function automatic q_t sat32(input logic signed [63:0] v);
		q_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = q_t'(v);
		return r;
	endfunction

	function automatic ucode_t uc_word(input jmp_t j, input logic [PCW-1:0] to,
			input logic m, input a_sel_t a, input b_sel_t b, input acc_op_t ac,
			input wr_op_t wr);
		ucode_t w;
		w.jmp    = j;
		w.jmp_to = to;
		w.mul_en = m;
		w.a_sel  = a;
		w.b_sel  = b;
		w.acc_op = ac;
		w.wr_op  = wr;
		return w;
	endfunction

	// multiply into the product register; the next step consumes the rounded product
	function automatic ucode_t ucode_rom(input logic [PCW-1:0] pc);
		ucode_t w;
		unique case (pc)
			4'd0:  w = uc_word(J_WAIT_IN, PC_OUT, 1'b0, A_RATE, B_TD, ACC_HOLD, WR_NONE);
			4'd1:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_RATE, B_TD, ACC_HOLD, WR_NONE);
			4'd2:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_VD, B_T, ACC_HOLD, WR_U);
			4'd3:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_CMD_JD, B_LAMBDA, ACC_LOAD, WR_NONE);
			4'd4:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_U, B_S2B, ACC_ADD, WR_NONE);
			4'd5:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_VEL, B_KV, ACC_LOAD, WR_JDN);
			4'd6:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_POS_JDN, B_KP, ACC_ADD, WR_NONE);
			4'd7:  w = uc_word(J_NEXT, PC_WAIT, 1'b0, A_RATE, B_TD, ACC_ADD, WR_NONE);
			4'd8:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_ACC, B_INVD, ACC_HOLD, WR_NONE);
			4'd9:  w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_JDN_POS, B_KP, ACC_HOLD, WR_VDN);
			4'd10: w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_VDN_VEL, B_KV, ACC_LOAD, WR_NONE);
			4'd11: w = uc_word(J_NEXT, PC_WAIT, 1'b0, A_RATE, B_TD, ACC_ADD, WR_NONE);
			4'd12: w = uc_word(J_NEXT, PC_WAIT, 1'b1, A_ACC, B_S2OB, ACC_HOLD, WR_TAU);
			4'd13: w = uc_word(J_NEXT, PC_WAIT, 1'b0, A_RATE, B_TD, ACC_HOLD, WR_WOUT);
			4'd14: w = uc_word(J_WAIT_OUT, PC_WAIT, 1'b0, A_RATE, B_TD, ACC_HOLD, WR_NONE);
			default: w = uc_word(J_NEXT, PC_WAIT, 1'b0, A_RATE, B_TD, ACC_HOLD, WR_NONE);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/wvsc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wvsc_datapath
// Shared multiplier with Q16.16 rounding and saturation, accumulator and
// result registers, steered by one control word per cycle.
// ----------------------------------------------------------------------------
module wvsc_datapath import wvsc_pkg::*; (
	input  wire logic    clk,
	input  wire ucode_t  uc,
	input  wire opnd_t   op,
	input  wire gains_t  g,
	output dp_res_t      res
);

	logic signed [63:0] prod_q;
	logic signed [33:0] acc_q;
	dp_res_t            res_q;

	q_t    q;
	q_t    acc_sat;
	q_t    a_op;
	gain_t b_op;
	q_t    d_cmd_jd;
	q_t    d_pos_jdn;
	q_t    d_vdn_vel;
	q_t    d_jdn_pos;

	always_comb begin
		q         = sat32((prod_q + 64'sd32768) >>> 16);
		acc_sat   = sat32(64'(acc_q));
		d_cmd_jd  = sat32(64'($signed(op.cmd)) - 64'($signed(op.jd)));
		d_pos_jdn = sat32(64'($signed(op.pos)) - 64'($signed(res_q.jdn)));
		d_vdn_vel = sat32(64'($signed(res_q.vdn)) - 64'($signed(op.vel)));
		d_jdn_pos = sat32(64'($signed(res_q.jdn)) - 64'($signed(op.pos)));
	end

	always_comb begin
		unique case (uc.a_sel)
			A_RATE:    a_op = op.rate;
			A_VD:      a_op = op.vd;
			A_CMD_JD:  a_op = d_cmd_jd;
			A_U:       a_op = res_q.u;
			A_VEL:     a_op = op.vel;
			A_POS_JDN: a_op = d_pos_jdn;
			A_ACC:     a_op = acc_sat;
			A_VDN_VEL: a_op = d_vdn_vel;
			A_JDN_POS: a_op = d_jdn_pos;
			default:   a_op = op.rate;
		endcase
	end

	always_comb begin
		unique case (uc.b_sel)
			B_TD:     b_op = g.td;
			B_T:      b_op = g.t;
			B_LAMBDA: b_op = g.lambda;
			B_S2B:    b_op = g.s2b;
			B_KV:     b_op = g.kv;
			B_KP:     b_op = g.kp;
			B_INVD:   b_op = g.invd;
			B_S2OB:   b_op = g.s2ob;
			default:  b_op = g.td;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uc.mul_en) begin
			prod_q <= $signed(a_op) * $signed({1'b0, b_op});
		end
	end

	always_ff @(posedge clk) begin
		unique case (uc.acc_op)
			ACC_HOLD: ;
			ACC_LOAD: acc_q <= 34'(q);
			ACC_ADD:  acc_q <= acc_q + 34'(q);
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (uc.wr_op)
			WR_NONE: ;
			WR_U:    res_q.u    <= sat32(64'($signed(op.win)) - 64'(q));
			WR_JDN:  res_q.jdn  <= sat32(64'($signed(op.jd)) + 64'(acc_sat));
			WR_VDN:  res_q.vdn  <= q;
			WR_TAU:  res_q.tau  <= acc_sat;
			WR_WOUT: res_q.wout <= sat32(64'($signed(res_q.u)) - 64'(q));
			default: ;
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

// ===== hdl/wave_variable_slave_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wave_variable_slave_controller
// Slave side of a wave-variable link: decodes the incoming wave, updates the
// per-axis desired position and velocity, forms the PD torque and encodes
// the outgoing wave. Q16.16 throughout, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per joint axis.
//   Output channel (out_valid/out_ready) returns one result per request,
//   in order. The cfg channel writes gains by index; cfg_ready is always
//   high, and writes belong to idle periods.
//   A 15-step microprogram drives one shared 32x32 multiplier through ten
//   products; a request runs through the program before the next one can
//   be accepted, and its result is loaded on the final step.
//   A request with an axis of AXES or more skips the program: zeros out,
//   state untouched, straight to the final step.
//   The output is a register: the next request is accepted while a result
//   waits. If the receiver stalls, the program holds on its final step
//   until the output register frees up.
//   Reset restores the gain defaults and clears desired position and
//   velocity of every axis; there is no clearing pass.
// ----------------------------------------------------------------------------
module wave_variable_slave_controller import wvsc_pkg::*; #(
	parameter int unsigned AXES = AXES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [AXW-1:0]        axis,
	input  wire logic signed [DW-1:0]  wave_in,
	input  wire logic signed [DW-1:0]  wave_rate,
	input  wire logic signed [DW-1:0]  joint_cmd,
	input  wire logic signed [DW-1:0]  meas_vel,
	input  wire logic signed [DW-1:0]  meas_pos,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [AXW-1:0]             axis_out,
	output logic signed [DW-1:0]       torque_out,
	output logic signed [DW-1:0]       wave_out,
	output logic signed [DW-1:0]       decoded_wave,
	output logic signed [DW-1:0]       desired_pos_out,
	output logic signed [DW-1:0]       desired_vel_out,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CIW-1:0]        cfg_index,
	input  wire logic [GW-1:0]         cfg_data
);

	localparam int unsigned IW = (AXES > 1) ? $clog2(AXES) : 1;

	logic [PCW-1:0] pc_q;
	ucode_t         uc;
	logic           in_fire;
	logic           axis_ok;
	logic           out_load;
	logic           bad_q;
	logic [AXW-1:0] axis_q;
	logic [IW-1:0]  idx_q;
	q_t             win_q, rate_q, cmd_q, vel_q, pos_q;
	gains_t         g_q;
	q_t             dpos_q [AXES];
	q_t             dvel_q [AXES];
	opnd_t          op;
	dp_res_t        res;

	logic           out_valid_q;
	logic [AXW-1:0] axis_out_q;
	q_t             tau_out_q, wave_out_q, u_out_q, jd_out_q, vd_out_q;

	assign uc        = ucode_rom(pc_q);
	assign in_ready  = (pc_q == PC_WAIT);
	assign in_fire   = in_valid & in_ready;
	assign axis_ok   = (32'(axis) < AXES);
	assign out_load  = (uc.jmp == J_WAIT_OUT) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_WAIT;
			bad_q <= 1'b0;
		end else begin
			unique case (uc.jmp)
				J_NEXT: pc_q <= pc_q + 1'b1;
				J_WAIT_IN: begin
					if (in_fire) begin
						bad_q <= !axis_ok;
						pc_q  <= axis_ok ? pc_q + 1'b1 : uc.jmp_to;
					end
				end
				J_WAIT_OUT: begin
					if (out_load) begin
						pc_q <= uc.jmp_to;
					end
				end
				default: pc_q <= PC_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			axis_q <= axis;
			idx_q  <= IW'(axis);
			win_q  <= wave_in;
			rate_q <= wave_rate;
			cmd_q  <= joint_cmd;
			vel_q  <= meas_vel;
			pos_q  <= meas_pos;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q.t      <= RST_STEP_TIME;
			g_q.td     <= RST_DELAY_TIME;
			g_q.s2b    <= RST_SQRT_2B;
			g_q.s2ob   <= RST_SQRT_2_OV_B;
			g_q.invd   <= RST_INV_DAMPING;
			g_q.kp     <= RST_POS_GAIN;
			g_q.kv     <= RST_VEL_GAIN;
			g_q.lambda <= RST_DRIFT_GAIN;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEP_TIME:   g_q.t      <= cfg_data;
				REG_DELAY_TIME:  g_q.td     <= cfg_data;
				REG_SQRT_2B:     g_q.s2b    <= cfg_data;
				REG_SQRT_2_OV_B: g_q.s2ob   <= cfg_data;
				REG_INV_DAMPING: g_q.invd   <= cfg_data;
				REG_POS_GAIN:    g_q.kp     <= cfg_data;
				REG_VEL_GAIN:    g_q.kv     <= cfg_data;
				REG_DRIFT_GAIN:  g_q.lambda <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-axis desired state, written back as the result enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				dpos_q[i] <= '0;
				dvel_q[i] <= '0;
			end
		end else if (out_load && !bad_q) begin
			dpos_q[idx_q] <= res.jdn;
			dvel_q[idx_q] <= res.vdn;
		end
	end

	always_comb begin
		op.win  = win_q;
		op.rate = rate_q;
		op.cmd  = cmd_q;
		op.vel  = vel_q;
		op.pos  = pos_q;
		op.jd   = dpos_q[idx_q];
		op.vd   = dvel_q[idx_q];
	end

	wvsc_datapath u_dp (
		.clk (clk),
		.uc  (uc),
		.op  (op),
		.g   (g_q),
		.res (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			axis_out_q <= axis_q;
			if (bad_q) begin
				tau_out_q  <= '0;
				wave_out_q <= '0;
				u_out_q    <= '0;
				jd_out_q   <= '0;
				vd_out_q   <= '0;
			end else begin
				tau_out_q  <= res.tau;
				wave_out_q <= res.wout;
				u_out_q    <= res.u;
				jd_out_q   <= res.jdn;
				vd_out_q   <= res.vdn;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign axis_out        = axis_out_q;
	assign torque_out      = tau_out_q;
	assign wave_out        = wave_out_q;
	assign decoded_wave    = u_out_q;
	assign desired_pos_out = jd_out_q;
	assign desired_vel_out = vd_out_q;

endmodule
`default_nettype wire

// ===== hdl/wvsc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wvsc_checker
// Port-level checks on the wave-variable slave controller, bound to the top.
// ----------------------------------------------------------------------------
module wvsc_checker import wvsc_pkg::*; #(
	parameter int unsigned AXES = AXES_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic [AXW-1:0]       axis,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [AXW-1:0]       axis_out,
	input wire logic signed [DW-1:0] torque_out,
	input wire logic signed [DW-1:0] wave_out,
	input wire logic signed [DW-1:0] decoded_wave,
	input wire logic signed [DW-1:0] desired_pos_out,
	input wire logic signed [DW-1:0] desired_vel_out
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(axis_out)
			&& $stable(torque_out) && $stable(wave_out) && $stable(decoded_wave)
			&& $stable(desired_pos_out) && $stable(desired_vel_out))
		else $error("stalled result changed");

	// one request in flight: no acceptance in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// out-of-range axis gives an all-zero result
	a_bad_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(axis_out) >= AXES) |-> torque_out == '0 && wave_out == '0
			&& decoded_wave == '0 && desired_pos_out == '0 && desired_vel_out == '0)
		else $error("nonzero result for out-of-range axis");

	// an out-of-range request never reaches the program
	a_bad_axis_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (32'(axis) >= AXES) && !out_valid |=> ##1 out_valid)
		else $error("out-of-range axis not answered at once");

endmodule

bind wave_variable_slave_controller wvsc_checker #(.AXES(AXES)) u_wvsc_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wave-variable slave controller. A local
// Q16.16 model of the per-axis wave decode, desired position/velocity update,
// PD torque and wave encode predicts every result; the checker compares
// each returned result field by field, in order. Traffic runs in bursts with
// random gaps against a receiver with changing stall patterns, across
// several gain settings including all-zero and all-max.
// ----------------------------------------------------------------------------
module testbench import wvsc_pkg::*; ();

	localparam int unsigned N_AXES = AXES_DEF;
	localparam int unsigned N_REGS = 8;
	localparam q_t    Q_MAX    = 32'sh7FFF_FFFF;
	localparam q_t    Q_MIN    = 32'sh8000_0000;
	localparam gain_t GAIN_MAX = '1;
	localparam int    DRAIN    = 30;

	typedef struct {
		logic [AXW-1:0] ax;
		q_t win;
		q_t rate;
		q_t cmd;
		q_t vel;
		q_t pos;
	} joint_req_t;

	typedef struct {
		logic [AXW-1:0] ax;
		q_t tau;
		q_t wout;
		q_t u;
		q_t jdn;
		q_t vdn;
	} joint_res_t;

	typedef gain_t gain_set_t [0:N_REGS-1];

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [AXW-1:0] axis = '0;
	logic signed [DW-1:0] wave_in = '0;
	logic signed [DW-1:0] wave_rate = '0;
	logic signed [DW-1:0] joint_cmd = '0;
	logic signed [DW-1:0] meas_vel = '0;
	logic signed [DW-1:0] meas_pos = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [AXW-1:0] axis_out;
	logic signed [DW-1:0] torque_out;
	logic signed [DW-1:0] wave_out;
	logic signed [DW-1:0] decoded_wave;
	logic signed [DW-1:0] desired_pos_out;
	logic signed [DW-1:0] desired_vel_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIW-1:0] cfg_index = '0;
	logic [GW-1:0] cfg_data = '0;

	gain_t gain_m [0:N_REGS-1];
	q_t jd_m [0:N_AXES-1];
	q_t vd_m [0:N_AXES-1];
	joint_res_t expected_q [$];

	int errors = 0;
	int n_sent = 0;
	int n_unused = 0;
	int n_checked = 0;
	int n_gain_sets = 0;
	int burst_left = 0;
	int hold_req = 0;
	int hold_left = 0;
	int rx_left = 0;
	int beat_cnt = 0;
	rx_mode_t rx_mode = RX_OPEN;

	wave_variable_slave_controller u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.axis            (axis),
		.wave_in         (wave_in),
		.wave_rate       (wave_rate),
		.joint_cmd       (joint_cmd),
		.meas_vel        (meas_vel),
		.meas_pos        (meas_pos),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.axis_out        (axis_out),
		.torque_out      (torque_out),
		.wave_out        (wave_out),
		.decoded_wave    (decoded_wave),
		.desired_pos_out (desired_pos_out),
		.desired_vel_out (desired_vel_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic q_t clamp32(input longint v);
		q_t r;
		if (v > longint'(Q_MAX))
			r = Q_MAX;
		else if (v < longint'(Q_MIN))
			r = Q_MIN;
		else
			r = q_t'(v);
		return r;
	endfunction

	function automatic q_t qadd(input q_t a, input q_t b);
		return clamp32(longint'(a) + longint'(b));
	endfunction

	function automatic q_t qsub(input q_t a, input q_t b);
		return clamp32(longint'(a) - longint'(b));
	endfunction

	// round to nearest, ties up: floor((a*g + 2^15) / 2^16)
	function automatic q_t gmul(input q_t a, input gain_t g);
		longint p;
		p = longint'(a) * longint'({1'b0, g}) + 64'sd32768;
		return clamp32(p >>> 16);
	endfunction

	function automatic joint_res_t advance_axis(input joint_req_t r);
		joint_res_t e;
		q_t jd;
		q_t vd;
		e = '{ax: r.ax, tau: '0, wout: '0, u: '0, jdn: '0, vdn: '0};
		if (r.ax >= N_AXES)
			return e;
		jd = jd_m[r.ax];
		vd = vd_m[r.ax];
		e.u = qsub(r.win, gmul(r.rate, gain_m[REG_DELAY_TIME]));
		e.jdn = qadd(jd, qadd(gmul(vd, gain_m[REG_STEP_TIME]),
			gmul(qsub(r.cmd, jd), gain_m[REG_DRIFT_GAIN])));
		e.vdn = gmul(clamp32(longint'(gmul(e.u, gain_m[REG_SQRT_2B]))
			+ longint'(gmul(r.vel, gain_m[REG_VEL_GAIN]))
			+ longint'(gmul(qsub(r.pos, e.jdn), gain_m[REG_POS_GAIN]))),
			gain_m[REG_INV_DAMPING]);
		e.tau = qadd(gmul(qsub(e.vdn, r.vel), gain_m[REG_VEL_GAIN]),
			gmul(qsub(e.jdn, r.pos), gain_m[REG_POS_GAIN]));
		e.wout = qsub(e.u, gmul(e.tau, gain_m[REG_SQRT_2_OV_B]));
		jd_m[r.ax] = e.jdn;
		vd_m[r.ax] = e.vdn;
		return e;
	endfunction

	function automatic gain_set_t default_gains();
		gain_set_t g;
		g[REG_STEP_TIME]   = RST_STEP_TIME;
		g[REG_DELAY_TIME]  = RST_DELAY_TIME;
		g[REG_SQRT_2B]     = RST_SQRT_2B;
		g[REG_SQRT_2_OV_B] = RST_SQRT_2_OV_B;
		g[REG_INV_DAMPING] = RST_INV_DAMPING;
		g[REG_POS_GAIN]    = RST_POS_GAIN;
		g[REG_VEL_GAIN]    = RST_VEL_GAIN;
		g[REG_DRIFT_GAIN]  = RST_DRIFT_GAIN;
		return g;
	endfunction

	// ------------------------------------------------------------- stimulus

	function automatic joint_req_t make_req(input int unsigned ax, input q_t w, input q_t r,
			input q_t c, input q_t v, input q_t p);
		joint_req_t q;
		q = '{ax: ax[AXW-1:0], win: w, rate: r, cmd: c, vel: v, pos: p};
		return q;
	endfunction

	function automatic q_t rand_q();
		q_t v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom();
			2: begin
				case ($urandom_range(0, 4))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = '0;
					3: v = 32'sd1;
					default: v = -32'sd1;
				endcase
			end
			default: v = q_t'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
		endcase
		return v;
	endfunction

	function automatic joint_req_t rand_req();
		int unsigned ax;
		ax = ($urandom_range(0, 11) == 0) ? N_AXES : $urandom_range(0, N_AXES - 1);
		if ($urandom_range(0, 19) == 0)
			ax = $urandom_range(0, (1 << AXW) - 1);
		return make_req(ax, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
	endfunction

	function automatic gain_set_t rand_gains();
		gain_set_t g;
		gain_set_t d;
		d = default_gains();
		for (int i = 0; i < N_REGS; i++) begin
			case ($urandom_range(0, 9))
				0: g[i] = gain_t'($urandom());
				1: g[i] = $urandom_range(0, 1) ? GAIN_MAX : '0;
				2, 3: g[i] = gain_t'($urandom_range(0, 32'h10_0000));
				default: g[i] = gain_t'($urandom_range(0, 2 * int'(d[i]) + 64000));
			endcase
		end
		return g;
	endfunction

	task automatic send_req(input joint_req_t r);
		in_valid  <= 1'b1;
		axis      <= r.ax;
		wave_in   <= r.win;
		wave_rate <= r.rate;
		joint_cmd <= r.cmd;
		meas_vel  <= r.vel;
		meas_pos  <= r.pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_q.push_back(advance_axis(r));
		n_sent++;
		if (r.ax >= N_AXES)
			n_unused++;
	endtask

	// bursts of random length, random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_gains(input gain_set_t g);
		wait_idle();
		for (int i = 0; i < N_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CIW'(i);
			cfg_data  <= g[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			gain_m[i] = g[i];
		end
		cfg_valid <= 1'b0;
		n_gain_sets++;
	endtask

	task automatic send_extremes(input int unsigned ax);
		send_req(make_req(ax, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
		send_req(make_req(ax, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
		send_req(make_req(ax, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555));
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		for (int unsigned a = 0; a < N_AXES; a++)
			send_req(make_req(a, '0, '0, '0, '0, '0));
		send_req(make_req(0, 32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000,
			-32'sh0000_4000, 32'sh0000_1000));
		send_extremes(1);
		send_req(make_req(2, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_req(make_req(N_AXES, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_req(make_req(N_AXES, 32'shAAAA_AAAA, 32'sh5555_5555, Q_MIN, -32'sd1, 32'sd1));
	endtask

	task automatic test_gain_extremes();
		gain_set_t g;
		for (int i = 0; i < N_REGS; i++)
			g[i] = '0;
		write_gains(g);
		send_extremes(0);
		for (int i = 0; i < N_REGS; i++)
			g[i] = GAIN_MAX;
		write_gains(g);
		send_extremes(2);
		send_req(make_req(0, '0, 32'sd1, 32'sd1, -32'sd1, '0));
		g = default_gains();
		g[REG_DELAY_TIME]  = GAIN_MAX;
		g[REG_SQRT_2_OV_B] = GAIN_MAX;
		write_gains(g);
		send_req(make_req(1, Q_MAX, Q_MIN, '0, '0, '0));
		send_req(make_req(1, Q_MIN, Q_MAX, '0, '0, '0));
		write_gains(default_gains());
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph != 0)
				write_gains(rand_gains());
			for (int i = 0; i < 110; i++) begin
				send_req(rand_req());
				pace_sender();
			end
		end
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		wait_idle();
		hold_req = 400;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_req(rand_req());
	endtask

	// ------------------------------------------------------------- receiver

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(32, 200);
			end else begin
				rx_left--;
			end
			beat_cnt++;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 7) != 0);
				default:   out_ready <= (beat_cnt % 5) < 3;
			endcase
		end
	end

	// -------------------------------------------------------------- checker

	task automatic check_field(input string name, input q_t exp_v, input q_t act_v);
		if (exp_v !== act_v) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
					$time, name, exp_v, exp_v, act_v, act_v);
		end
	endtask

	always @(posedge clk) begin : result_check
		joint_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending, axis_out %0d", $time, axis_out);
			end else begin
				e = expected_q.pop_front();
				check_field("axis_out", q_t'(e.ax), q_t'(axis_out));
				check_field("torque_out", e.tau, torque_out);
				check_field("wave_out", e.wout, wave_out);
				check_field("decoded_wave", e.u, decoded_wave);
				check_field("desired_pos_out", e.jdn, desired_pos_out);
				check_field("desired_vel_out", e.vdn, desired_vel_out);
				n_checked++;
			end
		end
	end

	// ----------------------------------------------------------------- main

	initial begin
		gain_m = default_gains();
		for (int a = 0; a < N_AXES; a++) begin
			jd_m[a] = '0;
			vd_m[a] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_gain_extremes();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_q.size());
		end
		$display("Coverage: %0d requests (%0d on an unused axis), %0d results checked,",
			n_sent, n_unused, n_checked);
		$display("          %0d gain settings, one long receiver hold-off; %0d errors.",
			n_gain_sets, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results still pending", $time, expected_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/wvsc_pkg.sv
hdl/wvsc_datapath.sv
hdl/wave_variable_slave_controller.sv
hdl/wvsc_checker.sv
verif/testbench.sv
